// ===== rtl/ppid_pkg.sv =====
// Shared types and constants for the positional PID controller.
// Holds register indexes, reset values and the structs passed between stages.
// No dependencies.
package ppid_pkg;

   // Field widths
   localparam int unsigned VAL_W  = 32;  // signed Q16.16 values
   localparam int unsigned REG_W  = 31;  // unsigned register values
   localparam int unsigned IDX_W  = 3;   // register index
   localparam int unsigned FRAC_G = 24;  // fraction bits of a Q8.24 gain

   // Term widths after the floor shift by FRAC_G
   localparam int unsigned PI_W  = 39;   // P and I terms
   localparam int unsigned D_W   = 40;   // D term (33-bit difference)
   localparam int unsigned SUM_W = 42;   // sum of three terms

   // Register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_PROP_GAIN     = 3'd0,
      REG_INTEG_GAIN_TS = 3'd1,
      REG_DERIV_GAIN_TS = 3'd2,
      REG_DEAD_BAND     = 3'd3,
      REG_INTEG_LIMIT   = 3'd4,
      REG_OUT_LIMIT     = 3'd5
   } reg_index_type;

   // Reset values
   localparam logic [REG_W-1:0] RST_PROP_GAIN     = 31'd16777216;
   localparam logic [REG_W-1:0] RST_INTEG_GAIN_TS = 31'd0;
   localparam logic [REG_W-1:0] RST_DERIV_GAIN_TS = 31'd0;
   localparam logic [REG_W-1:0] RST_DEAD_BAND     = 31'd13107;
   localparam logic [REG_W-1:0] RST_INTEG_LIMIT   = 31'd786432;
   localparam logic [REG_W-1:0] RST_OUT_LIMIT     = 31'd786432;

   // Register file contents
   typedef struct packed {
      logic [REG_W-1:0] prop_gain;
      logic [REG_W-1:0] integ_gain_ts;
      logic [REG_W-1:0] deriv_gain_ts;
      logic [REG_W-1:0] dead_band;
      logic [REG_W-1:0] integ_limit;
      logic [REG_W-1:0] out_limit;
   } cfg_type;

   // Error stage to multiply stage
   typedef struct packed {
      logic                    held;
      logic signed [VAL_W-1:0] err;
      logic signed [VAL_W-1:0] acc;
      logic signed [VAL_W:0]   diff;
   } err_stage_type;

   // Multiply stage to output stage
   typedef struct packed {
      logic                   held;
      logic signed [PI_W-1:0] p_term;
      logic signed [PI_W-1:0] i_term;
      logic signed [D_W-1:0]  d_term;
   } mul_stage_type;

endpackage

// ===== rtl/ppid_csr.sv =====
// Configuration register file for the positional PID controller.
// Depends on ppid_pkg for register indexes and reset values.
module ppid_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ppid_pkg::IDX_W-1:0]  csr_index,
   input  logic [ppid_pkg::VAL_W-1:0]  csr_wdata,
   output ppid_pkg::cfg_type           cfg
);
   import ppid_pkg::*;

   cfg_type          cfg_ff;
   logic [REG_W-1:0] wval;

   assign csr_ready = 1'b1;
   assign wval      = csr_wdata[REG_W-1:0];  // top bit ignored
   assign cfg       = cfg_ff;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= RST_PROP_GAIN;
         cfg_ff.integ_gain_ts <= RST_INTEG_GAIN_TS;
         cfg_ff.deriv_gain_ts <= RST_DERIV_GAIN_TS;
         cfg_ff.dead_band     <= RST_DEAD_BAND;
         cfg_ff.integ_limit   <= RST_INTEG_LIMIT;
         cfg_ff.out_limit     <= RST_OUT_LIMIT;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_PROP_GAIN:     cfg_ff.prop_gain     <= wval;
            REG_INTEG_GAIN_TS: cfg_ff.integ_gain_ts <= wval;
            REG_DERIV_GAIN_TS: cfg_ff.deriv_gain_ts <= wval;
            REG_DEAD_BAND:     cfg_ff.dead_band     <= wval;
            REG_INTEG_LIMIT:   cfg_ff.integ_limit   <= wval;
            REG_OUT_LIMIT:     cfg_ff.out_limit     <= wval;
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/ppid_err_stage.sv =====
// Input register, error saturation, dead band test and clamped integrator.
// Holds the previous error and integ_sum. Depends on ppid_pkg.
module ppid_err_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  ppid_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [ppid_pkg::VAL_W-1:0] req_setpoint,
   input  logic signed [ppid_pkg::VAL_W-1:0] req_measured,
   output logic                              st_valid,
   input  logic                              st_ready,
   output ppid_pkg::err_stage_type           st_data
);
   import ppid_pkg::*;

   logic                    in_valid_ff;
   logic signed [VAL_W-1:0] sp_ff, ms_ff;
   logic                    st_valid_ff;
   err_stage_type           st_data_ff, st_data_in;
   logic signed [VAL_W-1:0] old_err_ff, integ_sum_ff;

   logic                    st_free, advance;
   logic signed [VAL_W:0]   raw_diff, err33, mag, acc_raw, lim33, neg_lim33;
   logic signed [VAL_W-1:0] err, acc;
   logic                    outside;

   assign st_free   = !st_valid_ff || st_ready;
   assign advance   = in_valid_ff && st_free;
   assign req_ready = !in_valid_ff || st_free;
   assign st_valid  = st_valid_ff;
   assign st_data   = st_data_ff;

   // Saturated error, dead band test, integrator clamp, derivative difference
   always_comb begin
      raw_diff = {sp_ff[VAL_W-1], sp_ff} - {ms_ff[VAL_W-1], ms_ff};
      if (raw_diff[VAL_W] != raw_diff[VAL_W-1]) begin
         err = raw_diff[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         err = raw_diff[VAL_W-1:0];
      end
      err33     = {err[VAL_W-1], err};
      mag       = err33[VAL_W] ? -err33 : err33;
      outside   = $unsigned(mag) > {2'b00, cfg.dead_band};
      acc_raw   = {integ_sum_ff[VAL_W-1], integ_sum_ff} + err33;
      lim33     = {2'b00, cfg.integ_limit};
      neg_lim33 = -lim33;
      if (acc_raw > lim33) begin
         acc = lim33[VAL_W-1:0];
      end else if (acc_raw < neg_lim33) begin
         acc = neg_lim33[VAL_W-1:0];
      end else begin
         acc = acc_raw[VAL_W-1:0];
      end
      st_data_in.held = !outside;
      st_data_in.err  = err;
      st_data_in.acc  = acc;
      st_data_in.diff = err33 - {old_err_ff[VAL_W-1], old_err_ff};
   end

   // Input register and stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_valid_ff  <= 1'b0;
         old_err_ff   <= '0;
         integ_sum_ff <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            st_valid_ff <= 1'b1;
            old_err_ff  <= err;
            if (outside) begin
               integ_sum_ff <= acc;
            end
         end else if (st_ready) begin
            st_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sp_ff <= req_setpoint;
         ms_ff <= req_measured;
      end
      if (advance) begin
         st_data_ff <= st_data_in;
      end
   end

endmodule

// ===== rtl/ppid_mul_stage.sv =====
// Three gain multiplies with floor shift to Q16.16 terms.
// Depends on ppid_pkg.
module ppid_mul_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  ppid_pkg::cfg_type       cfg,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  ppid_pkg::err_stage_type up_data,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output ppid_pkg::mul_stage_type dn_data
);
   import ppid_pkg::*;

   logic                      dn_valid_ff;
   mul_stage_type             dn_data_ff, dn_data_in;
   logic signed [2*VAL_W-1:0] p_full, i_full, d_full;
   logic                      advance;

   assign up_ready = !dn_valid_ff || dn_ready;
   assign advance  = up_valid && up_ready;
   assign dn_valid = dn_valid_ff;
   assign dn_data  = dn_data_ff;

   // Products; dropping the low bits is the floor shift
   always_comb begin
      p_full = $signed({1'b0, cfg.prop_gain}) * up_data.err;
      i_full = $signed({1'b0, cfg.integ_gain_ts}) * up_data.acc;
      d_full = $signed({1'b0, cfg.deriv_gain_ts}) * up_data.diff;
      dn_data_in.held   = up_data.held;
      dn_data_in.p_term = p_full[FRAC_G+PI_W-1:FRAC_G];
      dn_data_in.i_term = i_full[FRAC_G+PI_W-1:FRAC_G];
      dn_data_in.d_term = d_full[FRAC_G+D_W-1:FRAC_G];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (advance) begin
         dn_valid_ff <= 1'b1;
      end else if (dn_ready) begin
         dn_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dn_data_ff <= dn_data_in;
      end
   end

endmodule

// ===== rtl/ppid_out_stage.sv =====
// Term sum, hold selection, output clamp and result register.
// Holds prev_drive. Depends on ppid_pkg.
module ppid_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  ppid_pkg::cfg_type                 cfg,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  ppid_pkg::mul_stage_type           up_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ppid_pkg::VAL_W-1:0] rsp_drive,
   output logic                              rsp_clamped,
   output logic                              rsp_held
);
   import ppid_pkg::*;

   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] drive_ff, drive_in, prev_drive_ff;
   logic                    clamped_ff, clamped_in, held_ff;
   logic signed [SUM_W-1:0] sum, pre, lim;
   logic                    advance;

   assign up_ready    = !rsp_valid_ff || rsp_ready;
   assign advance     = up_valid && up_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = drive_ff;
   assign rsp_clamped = clamped_ff;
   assign rsp_held    = held_ff;

   // Held items reuse the previous result, which left this stage just before
   always_comb begin
      sum = SUM_W'(up_data.p_term) + SUM_W'(up_data.i_term) + SUM_W'(up_data.d_term);
      pre = up_data.held ? SUM_W'(prev_drive_ff) : sum;
      lim = {{(SUM_W-REG_W){1'b0}}, cfg.out_limit};
      if (pre > lim) begin
         drive_in   = lim[VAL_W-1:0];
         clamped_in = 1'b1;
      end else if (pre < -lim) begin
         drive_in   = (-lim[VAL_W-1:0]);
         clamped_in = 1'b1;
      end else begin
         drive_in   = pre[VAL_W-1:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         prev_drive_ff <= '0;
      end else if (advance) begin
         rsp_valid_ff  <= 1'b1;
         prev_drive_ff <= drive_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff   <= drive_in;
         clamped_ff <= clamped_in;
         held_ff    <= up_data.held;
      end
   end

endmodule

// ===== rtl/positional_pid_controller.sv =====
// Positional PID controller with dead band and integrator anti-windup.
// Top level: register file and three pipeline stages. Depends on ppid_pkg.
//
// Usage:
//   req_ channel carries one sample (setpoint, measured, signed Q16.16).
//   rsp_ channel returns one item per sample: drive (Q16.16), clamped, held.
//   csr_ channel writes gain and limit registers by index 0..5; csr_ready is
//   always high and indexes 6 and 7 are dropped. Write only while idle.
// Pipeline: input register, error/integrator stage, multiply stage, result
//   register. Once accepted, a sample moves through them in this order.
// Throughput: one sample per cycle while rsp_ready stays high; the multiply
//   stage (two 32x32-bit and one 32x33-bit products) sets the clock period.
// Stalls: each stage holds its item while the one after it is full, so up
//   to four samples sit in the pipeline while rsp_ready is low; req_ready
//   drops only when every stage is occupied.
// Reset: synchronous, clears the pipeline, the stored error, integ_sum and
//   prev_drive, and loads register defaults (unity P gain, zero I and D).
module positional_pid_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [ppid_pkg::VAL_W-1:0] req_setpoint,
   input  logic signed [ppid_pkg::VAL_W-1:0] req_measured,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ppid_pkg::VAL_W-1:0] rsp_drive,
   output logic                              rsp_clamped,
   output logic                              rsp_held,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ppid_pkg::IDX_W-1:0]        csr_index,
   input  logic [ppid_pkg::VAL_W-1:0]        csr_wdata
);
   import ppid_pkg::*;

   cfg_type       cfg;
   logic          err_valid, err_ready, mul_valid, mul_ready;
   err_stage_type err_data;
   mul_stage_type mul_data;

   ppid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppid_err_stage u_err (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .st_valid     (err_valid),
      .st_ready     (err_ready),
      .st_data      (err_data)
   );

   ppid_mul_stage u_mul (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (err_valid),
      .up_ready (err_ready),
      .up_data  (err_data),
      .dn_valid (mul_valid),
      .dn_ready (mul_ready),
      .dn_data  (mul_data)
   );

   ppid_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .up_valid    (mul_valid),
      .up_ready    (mul_ready),
      .up_data     (mul_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_drive   (rsp_drive),
      .rsp_clamped (rsp_clamped),
      .rsp_held    (rsp_held)
   );

endmodule

// ===== rtl/ppid_checker.sv =====
// Port-level checks for the positional PID controller, bound to the top.
// Depends on ppid_pkg for widths.
module ppid_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ppid_pkg::VAL_W-1:0] rsp_drive,
   input logic                              rsp_clamped,
   input logic                              rsp_held
);

   localparam logic [2:0] MAX_ITEMS = 3'd4;

   logic [2:0] items_ff, items_in;
   logic       take, give;

   assign take = req_valid && req_ready;
   assign give = rsp_valid && rsp_ready;

   // Items accepted but not yet delivered
   always_comb begin
      items_in = items_ff;
      if (take && !give) begin
         items_in = items_ff + 3'd1;
      end else if (give && !take) begin
         items_in = items_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff <= '0;
      end else begin
         items_ff <= items_in;
      end
   end

   // Stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_clamped) && $stable(rsp_held))
      else $error("stalled result changed");

   // No result without an item in flight
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> items_ff != 3'd0)
      else $error("result with no item in flight");

   // Pipeline never holds more than its four stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      items_ff <= MAX_ITEMS && (items_ff != MAX_ITEMS || !req_ready || give))
      else $error("pipeline occupancy exceeded");

   // Empty result slot means the pipeline can take a sample
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with free result slot");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind positional_pid_controller ppid_checker u_ppid_checker (.*);

// ===== dv/positional_pid_controller_tb.sv =====
// Testbench for positional_pid_controller: directed and random samples, register
// writes and back-pressure, with every result checked against a PID predictor.
// Depends on ppid_pkg and the controller RTL.
module positional_pid_controller_tb;
   import ppid_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 6;
   localparam int PIPE_LATENCY   = 4;
   localparam int LONG_STALL     = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PCT       = 22;
   localparam int ONE_Q16        = 65536;

   // Indexes the register file does not decode
   localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

   localparam logic signed [VAL_W-1:0] VAL_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN      = 32'sh8000_0000;
   localparam logic [VAL_W-1:0]        REG_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [VAL_W-1:0]        GAIN_UNITY   = 32'h0100_0000;

   typedef struct packed {
      logic signed [VAL_W-1:0] drive;
      logic                    clamped;
      logic                    held;
   } pid_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_setpoint;
   logic signed [VAL_W-1:0] req_measured;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_drive;
   logic                    rsp_clamped;
   logic                    rsp_held;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [IDX_W-1:0]        csr_index;
   logic [VAL_W-1:0]        csr_wdata;

   // Predictor copy of registers and loop state
   cfg_type                 cfg;
   logic signed [VAL_W-1:0] old_err;
   logic signed [VAL_W-1:0] integ_acc;
   logic signed [VAL_W-1:0] last_drive;

   pid_result_type expected_drives[$];
   int             failures       = 0;
   int             quiet_cycles   = 0;
   bit             idle_on        = 1'b1;
   bit             long_stall_req = 1'b0;

   positional_pid_controller dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .rsp_clamped  (rsp_clamped),
      .rsp_held     (rsp_held),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // One PID step: saturated error, dead band, clamped integral, floored terms
   function automatic pid_result_type compute_drive(logic signed [VAL_W-1:0] sp,
                                                    logic signed [VAL_W-1:0] ms);
      pid_result_type res;
      longint err, mag, acc, lim, total, db, gp, gi, gd;
      err = longint'(sp) - longint'(ms);
      if (err > longint'(VAL_MAX)) err = longint'(VAL_MAX);
      if (err < longint'(VAL_MIN)) err = longint'(VAL_MIN);
      mag = (err < 0) ? -err : err;
      db  = longint'(cfg.dead_band);
      gp  = longint'(cfg.prop_gain);
      gi  = longint'(cfg.integ_gain_ts);
      gd  = longint'(cfg.deriv_gain_ts);
      if (mag > db) begin
         acc = longint'(integ_acc) + err;
         lim = longint'(cfg.integ_limit);
         if (acc > lim) acc = lim;
         else if (acc < -lim) acc = -lim;
         integ_acc = acc[VAL_W-1:0];
         total = ((gp * err) >>> FRAC_G) + ((gi * acc) >>> FRAC_G)
               + ((gd * (err - longint'(old_err))) >>> FRAC_G);
         res.held = 1'b0;
      end else begin
         // hold: previous output, clamped again below by the present limit
         total    = longint'(last_drive);
         res.held = 1'b1;
      end
      lim         = longint'(cfg.out_limit);
      res.clamped = 1'b1;
      if (total > lim) total = lim;
      else if (total < -lim) total = -lim;
      else res.clamped = 1'b0;
      last_drive = total[VAL_W-1:0];
      old_err    = err[VAL_W-1:0];
      res.drive  = last_drive;
      return res;
   endfunction

   // Track register writes and accepted samples, check results, watchdog
   always @(posedge clock) begin : monitor
      pid_result_type want;
      if (reset) begin
         cfg.prop_gain     = RST_PROP_GAIN;
         cfg.integ_gain_ts = RST_INTEG_GAIN_TS;
         cfg.deriv_gain_ts = RST_DERIV_GAIN_TS;
         cfg.dead_band     = RST_DEAD_BAND;
         cfg.integ_limit   = RST_INTEG_LIMIT;
         cfg.out_limit     = RST_OUT_LIMIT;
         old_err           = '0;
         integ_acc         = '0;
         last_drive        = '0;
         expected_drives.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PROP_GAIN:     cfg.prop_gain     = csr_wdata[REG_W-1:0];
               REG_INTEG_GAIN_TS: cfg.integ_gain_ts = csr_wdata[REG_W-1:0];
               REG_DERIV_GAIN_TS: cfg.deriv_gain_ts = csr_wdata[REG_W-1:0];
               REG_DEAD_BAND:     cfg.dead_band     = csr_wdata[REG_W-1:0];
               REG_INTEG_LIMIT:   cfg.integ_limit   = csr_wdata[REG_W-1:0];
               REG_OUT_LIMIT:     cfg.out_limit     = csr_wdata[REG_W-1:0];
               default: ;  // spare indexes are dropped
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               $error("result with no sample pending: drive %0d", rsp_drive);
               failures++;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_drive !== want.drive) begin
                  $error("drive: expected %0d, got %0d", $signed(want.drive), rsp_drive);
                  failures++;
               end
               if (rsp_clamped !== want.clamped) begin
                  $error("clamped: expected %0b, got %0b", want.clamped, rsp_clamped);
                  failures++;
               end
               if (rsp_held !== want.held) begin
                  $error("held: expected %0b, got %0b", want.held, rsp_held);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_drives.push_back(compute_drive(req_setpoint, req_measured));
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: random idling, plus one long hold-off on request
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
         end
         rsp_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // Offer one sample; valid stays high after acceptance for the next item
   task automatic send_sample(input logic signed [VAL_W-1:0] sp,
                              input logic signed [VAL_W-1:0] ms);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_setpoint <= sp;
      req_measured <= ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop offering and wait for every pending result
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_all_regs(input logic [VAL_W-1:0] p, i, d, db, il, ol);
      wait_until_drained();
      write_reg(REG_PROP_GAIN, p);
      write_reg(REG_INTEG_GAIN_TS, i);
      write_reg(REG_DERIV_GAIN_TS, d);
      write_reg(REG_DEAD_BAND, db);
      write_reg(REG_INTEG_LIMIT, il);
      write_reg(REG_OUT_LIMIT, ol);
   endtask

   function automatic logic signed [VAL_W-1:0] extreme_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(2))
         0:       v = VAL_MAX;
         1:       v = VAL_MIN;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Mostly tracking errors near the dead band or moderate, some full-range noise
   task automatic random_sample(output logic signed [VAL_W-1:0] sp,
                                output logic signed [VAL_W-1:0] ms);
      int unsigned pick;
      longint      delta;
      pick = $urandom_range(99);
      ms   = $urandom;
      if (pick < 25) begin
         delta = longint'(cfg.dead_band) + longint'($urandom_range(4)) - 2;
         if ($urandom_range(1)) delta = -delta;
         sp = ms + delta[VAL_W-1:0];
      end else if (pick < 65) begin
         delta = longint'($urandom_range(1 << 22)) - (1 << 21);
         sp = ms + delta[VAL_W-1:0];
      end else if (pick < 85) begin
         sp = $urandom;
      end else begin
         sp = extreme_value();
         ms = extreme_value();
      end
   endtask

   function automatic logic [VAL_W-1:0] random_reg_value(logic [VAL_W-1:0] modest_max);
      logic [VAL_W-1:0] v;
      case ($urandom_range(5))
         0:       v = '0;
         1:       v = REG_ALL_ONES;
         2:       v = $urandom;
         default: v = $urandom_range(modest_max);
      endcase
      return v;
   endfunction

   // Reset values: dead band edges both ways, output clamp at default limit
   task automatic test_reset_defaults();
      send_sample(0, 0);
      send_sample(32'sd13107, 0);
      send_sample(32'sd13108, 0);
      send_sample(0, 32'sd13108);
      send_sample(20 * ONE_Q16, 0);
      send_sample(0, 0);
   endtask

   // Full gains and limits, zero dead band, error saturating both ways
   task automatic test_error_saturation();
      set_all_regs(REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, '0, REG_ALL_ONES, REG_ALL_ONES);
      send_sample(VAL_MAX, VAL_MIN);
      send_sample(VAL_MIN, VAL_MAX);
      send_sample(VAL_MAX, VAL_MAX);
      send_sample(VAL_MIN, 0);
      send_sample(0, VAL_MIN);
   endtask

   // Largest dead band: positive saturated error sits on it, negative one exceeds it
   task automatic test_dead_band_max();
      wait_until_drained();
      write_reg(REG_DEAD_BAND, 32'h7FFF_FFFF);
      send_sample(VAL_MAX, VAL_MIN);
      send_sample(VAL_MIN, VAL_MAX);
   endtask

   // Zero output and integral limits force drive and integral to zero
   task automatic test_zero_limits();
      set_all_regs(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY >> 1, '0, '0, '0);
      send_sample(5 * ONE_Q16, 0);
      send_sample(-3 * ONE_Q16, 0);
      send_sample(0, 0);
   endtask

   // Held output clamped again after the output limit is lowered
   task automatic test_held_reclamp();
      set_all_regs(GAIN_UNITY, '0, '0, VAL_W'(RST_DEAD_BAND), VAL_W'(RST_INTEG_LIMIT),
                   40 * ONE_Q16);
      send_sample(30 * ONE_Q16, 0);
      wait_until_drained();
      write_reg(REG_OUT_LIMIT, 10 * ONE_Q16);
      send_sample(0, 0);
      send_sample(-30 * ONE_Q16, 0);
      wait_until_drained();
      write_reg(REG_OUT_LIMIT, 5 * ONE_Q16);
      send_sample(0, 0);
   endtask

   // Writes to undecoded indexes must leave every register alone
   task automatic test_spare_index();
      logic signed [VAL_W-1:0] sp, ms;
      wait_until_drained();
      write_reg(IDX_SPARE_LO, $urandom);
      write_reg(IDX_SPARE_HI, $urandom);
      repeat (2) begin
         random_sample(sp, ms);
         send_sample(sp, ms);
      end
   endtask

   // Receiver holds off while samples keep coming, so the pipeline fills
   task automatic test_backpressure();
      logic signed [VAL_W-1:0] sp, ms;
      long_stall_req = 1'b1;
      repeat (24) begin
         random_sample(sp, ms);
         send_sample(sp, ms);
      end
      wait_until_drained();
   endtask

   task automatic test_random_phase(input int n_items, input bit idling);
      logic signed [VAL_W-1:0] sp, ms;
      wait_until_drained();
      write_reg(REG_PROP_GAIN, random_reg_value(32'h0400_0000));
      write_reg(REG_INTEG_GAIN_TS, random_reg_value(32'h0400_0000));
      write_reg(REG_DERIV_GAIN_TS, random_reg_value(32'h0400_0000));
      write_reg(REG_DEAD_BAND, random_reg_value(32'h0002_0000));
      write_reg(REG_INTEG_LIMIT, random_reg_value(32'h0100_0000));
      write_reg(REG_OUT_LIMIT, random_reg_value(32'h0100_0000));
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO, $urandom);
      idle_on = idling;
      repeat (n_items) begin
         random_sample(sp, ms);
         send_sample(sp, ms);
      end
      wait_until_drained();
      idle_on = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_setpoint = '0;
      req_measured = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_error_saturation();
      test_dead_band_max();
      test_zero_limits();
      test_held_reclamp();
      test_spare_index();
      test_backpressure();
      test_random_phase(100, 1'b1);
      test_random_phase(100, 1'b1);
      test_random_phase(80, 1'b0);
      test_random_phase(100, 1'b1);

      wait_until_drained();
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ppid_pkg.sv
rtl/ppid_csr.sv
rtl/ppid_err_stage.sv
rtl/ppid_mul_stage.sv
rtl/ppid_out_stage.sv
rtl/positional_pid_controller.sv
rtl/ppid_checker.sv
dv/positional_pid_controller_tb.sv
